/* rtl/ltt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltt_pkg: shared types and constants of the LP text tokenizer
// Token and error codes, character codes, result record, position helpers.
// ----------------------------------------------------------------------------
package ltt_pkg;

	localparam int POS_W = 16;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [3:0] {
		TK_NAME   = 4'd0,
		TK_NUMBER = 4'd1,
		TK_PLUS   = 4'd2,
		TK_MINUS  = 4'd3,
		TK_TIMES  = 4'd4,
		TK_GE     = 4'd5,
		TK_LE     = 4'd6,
		TK_EQ     = 4'd7,
		TK_COMMA  = 4'd8,
		TK_EOL    = 4'd9,
		TK_MAX    = 4'd10,
		TK_MIN    = 4'd11,
		TK_ST     = 4'd12
	} token_kind_t;

	typedef enum logic [2:0] {
		ERR_NONE        = 3'd0,
		ERR_LETTER_NUM  = 3'd1,
		ERR_DOT_NAME    = 3'd2,
		ERR_UNKNOWN     = 3'd3,
		ERR_MISSING_EQ  = 3'd4
	} err_code_t;

	typedef enum logic [1:0] {
		PK_NONE   = 2'd0,
		PK_NAME   = 2'd1,
		PK_NUMBER = 2'd2
	} pend_kind_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_US    = 8'h5F;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;

	localparam logic [23:0] KW_MAX_UP = "MAX";
	localparam logic [23:0] KW_MAX_LO = "max";
	localparam logic [23:0] KW_MIN_UP = "MIN";
	localparam logic [23:0] KW_MIN_LO = "min";
	localparam logic [15:0] KW_ST_UP  = "ST";
	localparam logic [15:0] KW_ST_LO  = "st";

	typedef logic [2:0][7:0] prefix_t;

	typedef struct packed {
		token_kind_t      token_kind;
		logic [POS_W-1:0] start_pos;
		logic [POS_W-1:0] end_pos;
		err_code_t        error_code;
		logic             last_of_run;
	} result_t;

	function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
		return (p == POS_MAX) ? p : p + 1'b1;
	endfunction

	// prefix[0] holds the first character of the name
	function automatic token_kind_t name_kind(input prefix_t pfx, input logic [2:0] len);
		logic [23:0] w3;
		logic [15:0] w2;
		token_kind_t k;
		w3 = {pfx[0], pfx[1], pfx[2]};
		w2 = {pfx[0], pfx[1]};
		k = TK_NAME;
		if (len == 3'd3 && (w3 == KW_MAX_UP || w3 == KW_MAX_LO)) k = TK_MAX;
		if (len == 3'd3 && (w3 == KW_MIN_UP || w3 == KW_MIN_LO)) k = TK_MIN;
		if (len == 3'd2 && (w2 == KW_ST_UP || w2 == KW_ST_LO)) k = TK_ST;
		return k;
	endfunction

endpackage
`default_nettype wire

/* rtl/ltt_stream_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ltt_stream_if: valid/ready channels of the LP text tokenizer
// Byte channel into the block and token channel out of it.
// ----------------------------------------------------------------------------
interface ltt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       final_byte;

	modport source (output valid, output text_byte, output final_byte, input ready);
	modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface ltt_token_if;
	logic                      valid;
	logic                      ready;
	logic [3:0]                token_kind;
	logic [ltt_pkg::POS_W-1:0] start_pos;
	logic [ltt_pkg::POS_W-1:0] end_pos;
	logic [2:0]                error_code;
	logic                      last_of_run;

	modport source (output valid, output token_kind, output start_pos, output end_pos,
		output error_code, output last_of_run, input ready);
	modport sink   (input valid, input token_kind, input start_pos, input end_pos,
		input error_code, input last_of_run, output ready);
endinterface
`default_nettype wire

/* rtl/lp_text_tokenizer_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lp_text_tokenizer_top: streaming lexer for LP model text
// Results of a byte enter the result FIFO when it is accepted, in order.
// Throughput: one byte per cycle while the 4-entry result FIFO has room for
//   two results; the FIFO drains one result per cycle while tokens.ready is
//   high, so bytes that cause two results slow the input.
// Reset: arst_n clears the lexer state and empties the FIFO; no clearing pass.
// ----------------------------------------------------------------------------
module lp_text_tokenizer_top (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ltt_byte_if.sink     text,
	ltt_token_if.source  tokens
);

	// lexer state
	ltt_pkg::pend_kind_t            pk_q;
	logic [ltt_pkg::POS_W-1:0]      pstart_q;
	ltt_pkg::prefix_t               pfx_q;
	logic [2:0]                     plen_q;
	logic [ltt_pkg::POS_W-1:0]      pos_q;
	logic                           expect_q;
	logic                           sticky_q;

	// result FIFO
	ltt_pkg::result_t               fifo_q [ltt_pkg::FIFO_DEPTH];
	logic [ltt_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [ltt_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [ltt_pkg::FIFO_CNT_W-1:0] cnt_q;

	// next state and results
	ltt_pkg::pend_kind_t            w_pk;
	logic [ltt_pkg::POS_W-1:0]      w_start;
	ltt_pkg::prefix_t               w_pfx;
	logic [2:0]                     w_len;
	logic                           n_expect;
	logic                           do_flush;
	logic                           flush_v;
	logic [ltt_pkg::POS_W-1:0]      flush_end;
	logic                           tok_v;
	ltt_pkg::token_kind_t           tok_kind;
	logic [ltt_pkg::POS_W-1:0]      tok_end;
	ltt_pkg::err_code_t             err;
	ltt_pkg::result_t               flush_res;
	ltt_pkg::result_t               tok_res;
	ltt_pkg::result_t               r0;
	ltt_pkg::result_t               r1;
	logic [1:0]                     push_cnt;

	logic [7:0]                     c;
	logic                           fin;
	logic [ltt_pkg::POS_W-1:0]      here;
	logic [ltt_pkg::POS_W-1:0]      nxt;
	logic                           is_letter;
	logic                           is_digit;
	logic                           accept;
	logic                           pop;

	assign c      = text.text_byte;
	assign fin    = text.final_byte;
	assign here   = pos_q;
	assign nxt    = ltt_pkg::sat_inc(pos_q);
	assign accept = text.valid && text.ready;
	assign pop    = tokens.valid && tokens.ready;

	assign is_letter = (c inside {[ltt_pkg::CH_LO_A:ltt_pkg::CH_LO_Z],
		[ltt_pkg::CH_UP_A:ltt_pkg::CH_UP_Z], ltt_pkg::CH_US});
	assign is_digit  = (c inside {[ltt_pkg::CH_0:ltt_pkg::CH_9]});

	always_comb begin
		w_pk      = pk_q;
		w_start   = pstart_q;
		w_pfx     = pfx_q;
		w_len     = plen_q;
		n_expect  = 1'b0;
		do_flush  = 1'b0;
		flush_end = here;
		tok_v     = 1'b0;
		tok_kind  = ltt_pkg::TK_NAME;
		tok_end   = nxt;
		err       = ltt_pkg::ERR_NONE;
		flush_res = '0;

		if (sticky_q) begin
			n_expect = expect_q;
		end else if (expect_q) begin
			if (c != ltt_pkg::CH_EQ) err = ltt_pkg::ERR_MISSING_EQ;
		end else if (c inside {ltt_pkg::CH_NUL, ltt_pkg::CH_SPACE, ltt_pkg::CH_TAB}) begin
			do_flush = 1'b1;
		end else if (c == ltt_pkg::CH_NL) begin
			do_flush = 1'b1;
			tok_v    = 1'b1;
			tok_kind = ltt_pkg::TK_EOL;
		end else if (is_letter || is_digit) begin
			if (is_letter && pk_q == ltt_pkg::PK_NUMBER) begin
				err = ltt_pkg::ERR_LETTER_NUM;
			end else begin
				if (pk_q == ltt_pkg::PK_NONE) begin
					w_pk    = is_letter ? ltt_pkg::PK_NAME : ltt_pkg::PK_NUMBER;
					w_start = here;
					w_pfx   = '0;
					w_len   = 3'd0;
				end
				// digits extend a name's prefix, not a number's
				if (w_pk == ltt_pkg::PK_NAME) begin
					if (w_len < 3'd3) w_pfx[w_len[1:0]] = c;
					if (w_len < 3'd4) w_len = w_len + 3'd1;
				end
			end
		end else if (c == ltt_pkg::CH_DOT) begin
			if (pk_q == ltt_pkg::PK_NAME) begin
				err = ltt_pkg::ERR_DOT_NAME;
			end else if (pk_q == ltt_pkg::PK_NONE) begin
				w_pk    = ltt_pkg::PK_NUMBER;
				w_start = here;
				w_pfx   = '0;
				w_len   = 3'd0;
			end
		end else if (c inside {ltt_pkg::CH_PLUS, ltt_pkg::CH_MINUS, ltt_pkg::CH_STAR,
				ltt_pkg::CH_EQ, ltt_pkg::CH_COMMA, ltt_pkg::CH_LT, ltt_pkg::CH_GT}) begin
			do_flush = 1'b1;
			case (c)
				ltt_pkg::CH_PLUS:  tok_kind = ltt_pkg::TK_PLUS;
				ltt_pkg::CH_MINUS: tok_kind = ltt_pkg::TK_MINUS;
				ltt_pkg::CH_STAR:  tok_kind = ltt_pkg::TK_TIMES;
				ltt_pkg::CH_EQ:    tok_kind = ltt_pkg::TK_EQ;
				ltt_pkg::CH_GT:    tok_kind = ltt_pkg::TK_GE;
				ltt_pkg::CH_LT:    tok_kind = ltt_pkg::TK_LE;
				default:           tok_kind = ltt_pkg::TK_COMMA;
			endcase
			if (c == ltt_pkg::CH_LT || c == ltt_pkg::CH_GT) begin
				if (fin) begin
					err = ltt_pkg::ERR_MISSING_EQ;
				end else begin
					tok_v    = 1'b1;
					tok_end  = ltt_pkg::sat_inc(nxt);
					n_expect = 1'b1;
				end
			end else begin
				tok_v = 1'b1;
			end
		end else begin
			err = ltt_pkg::ERR_UNKNOWN;
		end

		if (err != ltt_pkg::ERR_NONE) begin
			tok_v    = 1'b1;
			tok_kind = ltt_pkg::TK_NAME;
			tok_end  = nxt;
		end else if (!sticky_q && fin && !do_flush && w_pk != ltt_pkg::PK_NONE) begin
			// end of text closes the pending token one past the final byte
			do_flush  = 1'b1;
			flush_end = nxt;
		end

		// a flush only yields a beat when a token is actually pending
		flush_v = do_flush && (w_pk != ltt_pkg::PK_NONE);

		flush_res.token_kind  = (w_pk == ltt_pkg::PK_NAME) ?
			ltt_pkg::name_kind(w_pfx, w_len) : ltt_pkg::TK_NUMBER;
		flush_res.start_pos   = w_start;
		flush_res.end_pos     = flush_end;
		flush_res.error_code  = ltt_pkg::ERR_NONE;
		flush_res.last_of_run = !tok_v;

		if (do_flush) begin
			w_pk  = ltt_pkg::PK_NONE;
			w_len = 3'd0;
		end

		tok_res.token_kind  = tok_kind;
		tok_res.start_pos   = here;
		tok_res.end_pos     = tok_end;
		tok_res.error_code  = err;
		tok_res.last_of_run = 1'b1;

		r0       = flush_v ? flush_res : tok_res;
		r1       = tok_res;
		push_cnt = {1'b0, flush_v} + {1'b0, tok_v};
	end

	// room for two results keeps a double beat from overrunning the FIFO
	assign text.ready = (cnt_q <= ltt_pkg::FIFO_CNT_W'(ltt_pkg::FIFO_DEPTH - 2));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_q     <= ltt_pkg::PK_NONE;
			pstart_q <= '0;
			pfx_q    <= '0;
			plen_q   <= 3'd0;
			pos_q    <= '0;
			expect_q <= 1'b0;
			sticky_q <= 1'b0;
		end else if (accept) begin
			if (fin) begin
				pk_q     <= ltt_pkg::PK_NONE;
				pstart_q <= '0;
				pfx_q    <= '0;
				plen_q   <= 3'd0;
				pos_q    <= '0;
				expect_q <= 1'b0;
				sticky_q <= 1'b0;
			end else if (!sticky_q) begin
				pk_q     <= w_pk;
				pstart_q <= w_start;
				pfx_q    <= w_pfx;
				plen_q   <= w_len;
				expect_q <= n_expect;
				if (err != ltt_pkg::ERR_NONE) sticky_q <= 1'b1;
				else pos_q <= nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && push_cnt != 2'd0) fifo_q[wr_ptr_q] <= r0;
		if (accept && push_cnt == 2'd2) fifo_q[wr_ptr_q + 1'b1] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (accept) wr_ptr_q <= wr_ptr_q + ltt_pkg::FIFO_PTR_W'(push_cnt);
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + (accept ? ltt_pkg::FIFO_CNT_W'(push_cnt) : '0)
				- ltt_pkg::FIFO_CNT_W'(pop);
		end
	end

	assign tokens.valid       = (cnt_q != '0);
	assign tokens.token_kind  = fifo_q[rd_ptr_q].token_kind;
	assign tokens.start_pos   = fifo_q[rd_ptr_q].start_pos;
	assign tokens.end_pos     = fifo_q[rd_ptr_q].end_pos;
	assign tokens.error_code  = fifo_q[rd_ptr_q].error_code;
	assign tokens.last_of_run = fifo_q[rd_ptr_q].last_of_run;

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ltt_pkg::FIFO_CNT_W'(ltt_pkg::FIFO_DEPTH))
		else $error("result FIFO overrun");

	a_sticky_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sticky_q |-> push_cnt == 2'd0)
		else $error("results produced while skipping after an error");

	a_equals_no_flush: assert property (@(posedge clk) disable iff (!arst_n)
		accept && expect_q && !sticky_q |-> !do_flush)
		else $error("flush on the byte after a comparison");

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && fin |=> pos_q == '0 && !sticky_q && pk_q == ltt_pkg::PK_NONE)
		else $error("state not cleared after final byte");

endmodule
`default_nettype wire
